[hdl/least_served_first_scheduler_assert.svh]
// assertion macros for the least-served-first scheduler
`ifndef LEAST_SERVED_FIRST_SCHEDULER_ASSERT_SVH
`define LEAST_SERVED_FIRST_SCHEDULER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// antecedent in this cycle implies consequent in the same cycle
`define LSFS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsfs assertion failed");
// antecedent in this cycle implies consequent in the next cycle
`define LSFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsfs assertion failed");
`else
`define LSFS_ASSERT_SAME(label, ante, cons)
`define LSFS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/lsfs_pkg.sv]
package lsfs_pkg;

  localparam int ID_W   = 6;
  localparam int CNT_W  = 8;
  localparam int SLOT_W = 5;
  localparam int TOT_W  = 16;
  localparam int STAT_W = 3;
  localparam int WAIT_W = 5;

  // configuration register indexes
  localparam logic CFG_SLOTS = 1'b0;
  localparam logic CFG_HELP  = 1'b1;

  // action codes
  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_SERVE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_QUEUED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLOT = 3'd1;
  localparam logic [STAT_W-1:0] ST_WAITING = 3'd2;
  localparam logic [STAT_W-1:0] ST_LIMIT   = 3'd3;
  localparam logic [STAT_W-1:0] ST_SERVED  = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd5;

  // commands from controller to datapath
  typedef struct packed {
    logic clear;    // clear one service count entry
    logic capture;  // latch the input beat, start count read
    logic exec;     // apply the item and load the result register
  } lsfs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_last;  // last service count entry is being cleared
  } lsfs_stat_t;

endpackage

[hdl/least_served_first_scheduler.sv]
// Least-served-first waiting room.
// Input stream: one beat is one item; in_tuser is the action (0 arrive,
// 1 serve), in_tdata carries the requester id and the server id.
// Result stream: exactly one beat per item; out_tuser is the status code,
// out_tdata carries the chosen id, server id, remaining services, waiting
// count and the two running totals.
// Configuration: cfg_we writes register cfg_index (0 usable slots,
// 1 help limit) with cfg_data; write only while the block is idle.
// Timing: the service count is read from the count memory into a register
// at the accepting edge, the item is applied in the execute step once the
// result register is free, and its result is registered at the end of that
// step; in_tready returns with the result, so no new item is accepted before
// the last one's result is registered. The sorted insert and the pop are done
// in the execute step by the shift cell row.
// The result register holds a finished beat while a new item is accepted;
// if the receiver stalls, the next item waits in its execute step.
// Reset: synchronous, active low; service counts are then cleared by a
// sweep over the MAX_REQUESTERS entries (64 by default) before the first
// beat is accepted. Configuration writes are taken during the sweep.
module least_served_first_scheduler
  import lsfs_pkg::*;
#(
  parameter int MAX_REQUESTERS = 64,
  parameter int QUEUE_DEPTH    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // requester_id[5:0], server_id[11:6], zero fill
  input  logic        in_tuser,   // action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // chosen_id[5:0], serving_id[11:6], priority_res[19:12],
  // waiting_count[24:20], total_requests[40:25], total_sessions[56:41], zero fill
  output logic [63:0] out_tdata,
  output logic [2:0]  out_tuser   // status
);

  lsfs_cmd_t  cmd;
  lsfs_stat_t stat;

  logic [STAT_W-1:0] res_status;
  logic [ID_W-1:0]   res_chosen_id;
  logic [ID_W-1:0]   res_serving_id;
  logic [CNT_W-1:0]  res_priority;
  logic [WAIT_W-1:0] res_waiting;
  logic [TOT_W-1:0]  res_requests;
  logic [TOT_W-1:0]  res_sessions;

  lsfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lsfs_dp #(
    .MAX_REQUESTERS (MAX_REQUESTERS),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_action       (in_tuser),
    .in_requester_id (in_tdata[5:0]),
    .in_server_id    (in_tdata[11:6]),
    .cmd             (cmd),
    .stat            (stat),
    .res_status      (res_status),
    .res_chosen_id   (res_chosen_id),
    .res_serving_id  (res_serving_id),
    .res_priority    (res_priority),
    .res_waiting     (res_waiting),
    .res_requests    (res_requests),
    .res_sessions    (res_sessions)
  );

  // result beat packing
  assign out_tuser = res_status;
  assign out_tdata = {7'd0, res_sessions, res_requests, res_waiting,
                      res_priority, res_serving_id, res_chosen_id};

`include "least_served_first_scheduler_assert.svh"

  // one item at a time: no second accept right after an accept
  `LSFS_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready)
  // a finished result is never overwritten while stalled
  `LSFS_ASSERT_SAME(a_no_overwrite, cmd.exec, !out_tvalid || out_tready)
  // no item is taken during the count clearing sweep
  `LSFS_ASSERT_SAME(a_clear_blocks, cmd.clear, !in_tready && !cmd.exec)

endmodule

[hdl/lsfs_ctrl.sv]
module lsfs_ctrl
  import lsfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  lsfs_stat_t stat,
  output lsfs_cmd_t  cmd
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t state_r;
  logic   in_tready_r;
  logic   out_tvalid_r;

  // commands
  assign cmd.clear   = (state_r == S_CLEAR);
  assign cmd.capture = in_tvalid && in_tready_r;
  assign cmd.exec    = (state_r == S_EXEC) && (!out_tvalid_r || out_tready);

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          if (stat.clear_last) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd.capture) begin
            state_r     <= S_EXEC;
            in_tready_r <= 1'b0;
          end
        end
        S_EXEC: begin
          if (cmd.exec) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_CLEAR;
          in_tready_r <= 1'b0;
        end
      endcase
      if (cmd.exec) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

endmodule

[hdl/lsfs_dp.sv]
module lsfs_dp
  import lsfs_pkg::*;
#(
  parameter int MAX_REQUESTERS = 64,
  parameter int QUEUE_DEPTH    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              in_action,
  input  logic [ID_W-1:0]   in_requester_id,
  input  logic [ID_W-1:0]   in_server_id,
  input  lsfs_cmd_t         cmd,
  output lsfs_stat_t        stat,
  output logic [STAT_W-1:0] res_status,
  output logic [ID_W-1:0]   res_chosen_id,
  output logic [ID_W-1:0]   res_serving_id,
  output logic [CNT_W-1:0]  res_priority,
  output logic [WAIT_W-1:0] res_waiting,
  output logic [TOT_W-1:0]  res_requests,
  output logic [TOT_W-1:0]  res_sessions
);

  localparam int IDX_W   = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
  localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_NUM  = 1 << ID_W;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // configuration registers
  logic [SLOT_W-1:0] slots_r;
  logic [CNT_W-1:0]  help_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOT_W'(16);
      help_r  <= CNT_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLOTS: slots_r <= cfg_data[SLOT_W-1:0];
        CFG_HELP:  help_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // requester id folded into the requester range, constant table
  logic [ID_W-1:0] mod_tab [ID_NUM];
  for (genvar g = 0; g < ID_NUM; g++) begin : g_mod
    assign mod_tab[g] = ID_W'(g % MAX_REQUESTERS);
  end

  // latched input beat
  logic            action_r;
  logic [ID_W-1:0] rid_r;
  logic [ID_W-1:0] sid_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_action;
      rid_r    <= mod_tab[in_requester_id];
      sid_r    <= in_server_id;
    end
  end

  // clear sweep counter over the service count memory
  logic [IDX_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign stat.clear_last = cmd.clear && (clr_cnt_r == IDX_W'(MAX_REQUESTERS - 1));

  // waiting room cells, sorted by service count, head at cell 0
  logic [ID_W-1:0]  cell_id_r  [QUEUE_DEPTH];
  logic [CNT_W-1:0] cell_key_r [QUEUE_DEPTH];
  logic [LEN_W-1:0] len_r;
  logic [TOT_W-1:0] req_tot_r;
  logic [TOT_W-1:0] ses_tot_r;

  // service count memory
  logic [CNT_W-1:0] cnt_mem [MAX_REQUESTERS];
  logic [CNT_W-1:0] cnt_rd_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [CNT_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
    if (cmd.capture) begin
      cnt_rd_r <= cnt_mem[IDX_W'(mod_tab[in_requester_id])];
    end
  end

  // per-cell compares
  logic [QUEUE_DEPTH-1:0] valid;
  logic [QUEUE_DEPTH-1:0] after;
  logic [QUEUE_DEPTH-1:0] match;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cmp
    assign valid[g] = (32'(g) < 32'(len_r));
    assign after[g] = !valid[g] || (cell_key_r[g] > cnt_rd_r);
    assign match[g] = valid[g] && (cell_id_r[g] == rid_r);
  end

  function automatic logic [CNT_W-1:0] remain(input logic [CNT_W-1:0] cnt,
                                              input logic [CNT_W-1:0] lim);
    remain = (cnt < lim) ? (lim - cnt) : '0;
  endfunction

  // item decision
  logic             full;
  logic             ins_en;
  logic             sh_en;
  logic             empty;
  logic [CNT_W-1:0] head_new;
  logic [STAT_W-1:0] status_nxt;
  logic [LEN_W-1:0]  len_nxt;

  assign full  = (32'(len_r) >= 32'(slots_r)) || (32'(len_r) >= 32'(QUEUE_DEPTH));
  assign empty = (len_r == '0);
  assign head_new = (cell_key_r[0] == CNT_MAX) ? CNT_MAX : cell_key_r[0] + 1'b1;

  always_comb begin
    ins_en     = 1'b0;
    sh_en      = 1'b0;
    status_nxt = ST_EMPTY;
    if (action_r == ACT_ARRIVE) begin
      if (full) begin
        status_nxt = ST_NO_SLOT;
      end else if (|match) begin
        status_nxt = ST_WAITING;
      end else if (cnt_rd_r >= help_r) begin
        status_nxt = ST_LIMIT;
      end else begin
        status_nxt = ST_QUEUED;
        ins_en     = cmd.exec;
      end
    end else if (!empty) begin
      status_nxt = ST_SERVED;
      sh_en      = cmd.exec;
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (ins_en) begin
      len_nxt = len_r + 1'b1;
    end else if (sh_en) begin
      len_nxt = len_r - 1'b1;
    end
  end

  // memory write port: clear sweep or count update on serve
  always_comb begin
    mem_we = cmd.clear || sh_en;
    mem_wa = cmd.clear ? clr_cnt_r : IDX_W'(cell_id_r[0]);
    mem_wd = cmd.clear ? '0 : head_new;
  end

  // cell row: insert with shift toward the tail, or shift toward the head
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic             prev_after;
    logic [ID_W-1:0]  prev_id;
    logic [CNT_W-1:0] prev_key;
    logic [ID_W-1:0]  next_id;
    logic [CNT_W-1:0] next_key;

    if (g == 0) begin : g_first
      assign prev_after = 1'b0;
      assign prev_id    = rid_r;
      assign prev_key   = cnt_rd_r;
    end else begin : g_inner
      assign prev_after = after[g-1];
      assign prev_id    = cell_id_r[g-1];
      assign prev_key   = cell_key_r[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign next_id  = cell_id_r[g];
      assign next_key = cell_key_r[g];
    end else begin : g_body
      assign next_id  = cell_id_r[g+1];
      assign next_key = cell_key_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (ins_en && after[g]) begin
        if (!prev_after) begin
          cell_id_r[g]  <= rid_r;
          cell_key_r[g] <= cnt_rd_r;
        end else begin
          cell_id_r[g]  <= prev_id;
          cell_key_r[g] <= prev_key;
        end
      end else if (sh_en) begin
        cell_id_r[g]  <= next_id;
        cell_key_r[g] <= next_key;
      end
    end
  end

  // room length and running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      req_tot_r <= '0;
      ses_tot_r <= '0;
    end else begin
      len_r <= len_nxt;
      if (ins_en) begin
        req_tot_r <= req_tot_r + 1'b1;
      end
      if (sh_en) begin
        ses_tot_r <= ses_tot_r + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status  <= status_nxt;
      res_waiting <= WAIT_W'(len_nxt);
      res_requests <= ins_en ? req_tot_r + 1'b1 : req_tot_r;
      res_sessions <= sh_en ? ses_tot_r + 1'b1 : ses_tot_r;
      if (action_r == ACT_ARRIVE) begin
        res_chosen_id  <= rid_r;
        res_serving_id <= '0;
        res_priority   <= remain(cnt_rd_r, help_r);
      end else if (empty) begin
        res_chosen_id  <= '0;
        res_serving_id <= '0;
        res_priority   <= '0;
      end else begin
        res_chosen_id  <= cell_id_r[0];
        res_serving_id <= sid_r;
        res_priority   <= remain(head_new, help_r);
      end
    end
  end

endmodule
